// ===== rtl/biou_pkg.sv =====
// package for the box intersection-over-union block
// default sizes for the top level and an edge count shared with the front end, no dependencies
package biou_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int NUM_EDGES      = 8;

endpackage

// ===== rtl/biou_front.sv =====
// front end: intersection edges, box extents, areas and union
// three pipeline stages with local flow control, uses biou_pkg
module biou_front #(
  parameter int COORD_BITS = 16
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_valid,
  output logic                                        in_ready,
  input  logic [biou_pkg::NUM_EDGES*COORD_BITS-1:0]   in_box,
  output logic                                        out_valid,
  input  logic                                        out_ready,
  output logic [2*COORD_BITS+1:0]                     out_num,
  output logic [2*COORD_BITS:0]                       out_den
);
  import biou_pkg::*;

  localparam int CW = COORD_BITS + 1;
  localparam int AW = 2 * COORD_BITS + 1;

  logic [COORD_BITS-1:0] al, at, ar, ab, bl, bt, br, bb;
  logic [COORD_BITS-1:0] il, it, ir, ib;

  logic          v1_r, v2_r, v3_r;
  logic          ready1, ready2, ready3;
  logic [CW-1:0] iw_r, ih_r, aw_r, ah_r, bw_r, bh_r;
  logic [CW-1:0] iw_nxt, ih_nxt, aw_nxt, ah_nxt, bw_nxt, bh_nxt;
  logic          empty_r, empty_nxt, empty2_r;
  logic [AW-1:0] inter_r, area_a_r, area_b_r;
  logic [AW-1:0] inter_nxt, area_a_nxt, area_b_nxt;
  logic [AW:0]   num_r, num_nxt;
  logic [AW-1:0] den_r, den_nxt;
  logic [AW:0]   area_sum;

  assign al = in_box[0*COORD_BITS +: COORD_BITS];
  assign at = in_box[1*COORD_BITS +: COORD_BITS];
  assign ar = in_box[2*COORD_BITS +: COORD_BITS];
  assign ab = in_box[3*COORD_BITS +: COORD_BITS];
  assign bl = in_box[4*COORD_BITS +: COORD_BITS];
  assign bt = in_box[5*COORD_BITS +: COORD_BITS];
  assign br = in_box[6*COORD_BITS +: COORD_BITS];
  assign bb = in_box[7*COORD_BITS +: COORD_BITS];

  assign ready3   = !v3_r || out_ready;
  assign ready2   = !v2_r || ready3;
  assign ready1   = !v1_r || ready2;
  assign in_ready = ready1;

  always_comb begin
    il = (al > bl) ? al : bl;
    it = (at > bt) ? at : bt;
    ir = (ar < br) ? ar : br;
    ib = (ab < bb) ? ab : bb;
    empty_nxt = (ir < il) || (ib < it);
    iw_nxt = CW'(ir) - CW'(il) + CW'(1);
    ih_nxt = CW'(ib) - CW'(it) + CW'(1);
    aw_nxt = CW'(ar) - CW'(al) + CW'(1);
    ah_nxt = CW'(ab) - CW'(at) + CW'(1);
    bw_nxt = CW'(br) - CW'(bl) + CW'(1);
    bh_nxt = CW'(bb) - CW'(bt) + CW'(1);
  end

  always_comb begin
    inter_nxt  = AW'(iw_r * ih_r);
    area_a_nxt = AW'(aw_r * ah_r);
    area_b_nxt = AW'(bw_r * bh_r);
  end

  always_comb begin
    area_sum = {1'b0, area_a_r} + {1'b0, area_b_r} - {1'b0, inter_r};
    if (empty2_r) begin
      num_nxt = '0;
      den_nxt = AW'(1);
    end else begin
      num_nxt = {1'b0, inter_r};
      den_nxt = area_sum[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (ready1) v1_r <= in_valid;
      if (ready2) v2_r <= v1_r;
      if (ready3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && in_valid) begin
      iw_r    <= iw_nxt;
      ih_r    <= ih_nxt;
      aw_r    <= aw_nxt;
      ah_r    <= ah_nxt;
      bw_r    <= bw_nxt;
      bh_r    <= bh_nxt;
      empty_r <= empty_nxt;
    end
    if (ready2 && v1_r) begin
      inter_r  <= inter_nxt;
      area_a_r <= area_a_nxt;
      area_b_r <= area_b_nxt;
      empty2_r <= empty_r;
    end
    if (ready3 && v2_r) begin
      num_r <= num_nxt;
      den_r <= den_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_num   = num_r;
  assign out_den   = den_r;

endmodule

// ===== rtl/biou_div_cell.sv =====
// one cell of the restoring divider chain, one quotient bit per cell
// registered output with local flow control, uses biou_pkg
module biou_div_cell #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [2*COORD_BITS+1:0] in_rem,
  input  logic [2*COORD_BITS:0]   in_den,
  input  logic [FRAC_BITS:0]      in_quot,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [2*COORD_BITS+1:0] out_rem,
  output logic [2*COORD_BITS:0]   out_den,
  output logic [FRAC_BITS:0]      out_quot
);
  import biou_pkg::*;

  localparam int AW = 2 * COORD_BITS + 1;
  localparam int QW = FRAC_BITS + 1;

  logic          v_r;
  logic          ge;
  logic [AW:0]   diff;
  logic [AW:0]   rem_r, rem_nxt;
  logic [AW-1:0] den_r;
  logic [QW-1:0] quot_r, quot_nxt;

  assign in_ready = !v_r || out_ready;

  always_comb begin
    ge       = in_rem >= {1'b0, in_den};
    diff     = in_rem - {1'b0, in_den};
    rem_nxt  = ge ? {diff[AW-1:0], 1'b0} : {in_rem[AW-1:0], 1'b0};
    quot_nxt = {in_quot[QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      rem_r  <= rem_nxt;
      den_r  <= in_den;
      quot_r <= quot_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_rem   = rem_r;
  assign out_den   = den_r;
  assign out_quot  = quot_r;

endmodule

// ===== rtl/box_intersection_over_union.sv =====
// Intersection over union of two inclusive-edge boxes, one box pair per clock sustained
// while the output accepts. Three front stages (extents, three parallel multipliers,
// union) are followed by a chain of FRAC_BITS+1 divider cells, one quotient bit per cell.
// Result is unsigned fixed point with FRAC_BITS fraction bits, truncated; empty overlap
// gives 0. Every stage has its own valid bit, so bubbles collapse under output stalls.
module box_intersection_over_union #(
  parameter int COORD_BITS = biou_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = biou_pkg::FRAC_BITS_DEF
) (
  input  logic                                                   clk,
  input  logic                                                   rst_n,
  input  logic                                                   in_tvalid,
  output logic                                                   in_tready,
  // a_left, a_top, a_right, a_bottom, b_left, b_top, b_right, b_bottom
  input  logic [((biou_pkg::NUM_EDGES*COORD_BITS+7)/8)*8-1:0]    in_tdata,
  output logic                                                   out_tvalid,
  input  logic                                                   out_tready,
  // overlap_ratio
  output logic [((FRAC_BITS+1+7)/8)*8-1:0]                       out_tdata
);
  import biou_pkg::*;

  localparam int AW    = 2 * COORD_BITS + 1;
  localparam int QW    = FRAC_BITS + 1;
  localparam int NC    = FRAC_BITS + 1;
  localparam int OUT_W = ((QW + 7) / 8) * 8;
  localparam logic [QW-1:0] RATIO_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic          cv    [0:NC];
  logic          crdy  [0:NC];
  logic [AW:0]   crem  [0:NC];
  logic [AW-1:0] cden  [0:NC];
  logic [QW-1:0] cquot [0:NC];

  biou_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_box   (in_tdata[NUM_EDGES*COORD_BITS-1:0]),
    .out_valid(cv[0]),
    .out_ready(crdy[0]),
    .out_num  (crem[0]),
    .out_den  (cden[0])
  );

  assign cquot[0] = '0;

  for (genvar i = 0; i < NC; i++) begin : g_cell
    biou_div_cell #(
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS (FRAC_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (cv[i]),
      .in_ready (crdy[i]),
      .in_rem   (crem[i]),
      .in_den   (cden[i]),
      .in_quot  (cquot[i]),
      .out_valid(cv[i+1]),
      .out_ready(crdy[i+1]),
      .out_rem  (crem[i+1]),
      .out_den  (cden[i+1]),
      .out_quot (cquot[i+1])
    );
  end

  assign crdy[NC]   = out_tready;
  assign out_tvalid = cv[NC];
  assign out_tdata  = OUT_W'(cquot[NC]);

  // ratio never above one
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (cquot[NC] <= RATIO_ONE))
    else $error("overlap ratio above one");

  // divider never sees a zero union
  assert property (@(posedge clk) disable iff (!rst_n)
    cv[0] |-> (cden[0] != '0))
    else $error("zero union entering divider");

  // input backpressure only when the whole pipe is full behind a stalled output
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled with room in pipeline");

  // a remainder entering the last cell stays below twice the divisor
  assert property (@(posedge clk) disable iff (!rst_n)
    cv[NC-1] |-> (crem[NC-1] < {cden[NC-1], 1'b0}))
    else $error("divider remainder out of range");

endmodule
